[src/fpp_pkg.sv]
package fpp_pkg;

  localparam int MAX_PAYLOAD = 32;
  localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
  localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 6;
  localparam int POS_W       = 5;
  localparam int STAT_W      = 3;
  localparam int CFG_IDX_W   = 2;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_BAD_HEAD = 3'd1,
    ST_TOO_LONG = 3'd2,
    ST_BAD_SUM  = 3'd3,
    ST_BAD_TAIL = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER = 2'd0,
    CFG_TAIL   = 2'd1,
    CFG_MAXLEN = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_COMMAND = 3'd1,
    PH_LENGTH  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CHECK   = 3'd4,
    PH_TAIL    = 3'd5,
    PH_EMIT_RD = 3'd6,
    PH_EMIT_WR = 3'd7
  } phase_t;

endpackage

[src/fpp_if.sv]
interface fpp_in_if;
  import fpp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fpp_out_if;
  import fpp_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [BYTE_W-1:0] command_code;
  logic [LEN_W-1:0]  frame_length;
  logic [BYTE_W-1:0] payload_byte;
  logic [POS_W-1:0]  byte_position;
  logic              last;

  modport source (output valid, output status, output command_code, output frame_length,
                  output payload_byte, output byte_position, output last, input ready);
  modport sink   (input valid, input status, input command_code, input frame_length,
                  input payload_byte, input byte_position, input last, output ready);
endinterface

[src/framed_packet_parser_core.sv]
// channel  dir  modport          payload
// rx       in   fpp_in_if.sink   rx_byte
// res      out  fpp_out_if.source status, command_code, frame_length,
//                                payload_byte, byte_position, last
// cfg      in   plain write      cfg_we, cfg_index, cfg_data
//
// one received byte is taken per cycle while the parser is collecting a frame
// a good tail after a nonempty payload starts a replay from the payload memory: each
//   payload beat is a memory read, then an output load; no byte is taken until it ends
// a single output register holds results; rx is held off while it is full and
//   not being taken, and during the replay
// rst is synchronous and clears control state; the payload memory is not cleared
module framed_packet_parser_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [fpp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fpp_pkg::BYTE_W-1:0]     cfg_data,
  fpp_in_if.sink                         rx,
  fpp_out_if.source                      res
);
  import fpp_pkg::*;

  logic [BYTE_W-1:0] header_byte;
  logic [BYTE_W-1:0] tail_byte;
  logic [LEN_W-1:0]  max_length;

  phase_t            phase, phase_next;
  logic [BYTE_W-1:0] held_command;
  logic [LEN_W-1:0]  held_length;
  logic [CNT_W-1:0]  fill_index;
  logic [CNT_W-1:0]  emit_idx;
  logic [BYTE_W-1:0] running_xor;

  logic              out_valid;
  status_t           out_status;
  logic [BYTE_W-1:0] out_command;
  logic [LEN_W-1:0]  out_length;
  logic [BYTE_W-1:0] out_payload;
  logic [POS_W-1:0]  out_pos;
  logic              out_last;

  logic              rx_fire;
  logic              out_free;
  logic [BYTE_W-1:0] b;
  logic [LEN_W-1:0]  limit;
  logic              len_ok;
  logic              sum_ok;
  logic              fill_done;
  logic              emit_last;

  logic              rx_ready;
  logic              mem_we;
  logic              mem_re;
  logic [BYTE_W-1:0] mem_rdata;
  logic              out_load;
  status_t           ld_status;
  logic [BYTE_W-1:0] ld_command;
  logic [LEN_W-1:0]  ld_length;
  logic [BYTE_W-1:0] ld_payload;
  logic [POS_W-1:0]  ld_pos;
  logic              ld_last;

  assign b         = rx.rx_byte;
  assign rx_fire   = rx.valid && rx_ready;
  assign out_free  = !out_valid || res.ready;
  assign limit     = (max_length < LEN_W'(MAX_PAYLOAD)) ? max_length : LEN_W'(MAX_PAYLOAD);
  assign len_ok    = b <= BYTE_W'(limit);
  assign sum_ok    = running_xor == b;
  assign fill_done = (fill_index + 1'b1) >= CNT_W'(held_length);
  assign emit_last = (emit_idx + 1'b1) == CNT_W'(held_length);

  fpp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PAYLOAD)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (fill_index[ADDR_W-1:0]),
    .wdata (b),
    .re    (mem_re),
    .raddr (emit_idx[ADDR_W-1:0]),
    .rdata (mem_rdata)
  );

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_HEADER: begin
        if (rx_fire && b == header_byte) phase_next = PH_COMMAND;
      end
      PH_COMMAND: begin
        if (rx_fire) phase_next = PH_LENGTH;
      end
      PH_LENGTH: begin
        if (rx_fire) begin
          if (!len_ok) phase_next = PH_HEADER;
          else if (b == '0) phase_next = PH_CHECK;
          else phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (rx_fire && fill_done) phase_next = PH_CHECK;
      end
      PH_CHECK: begin
        if (rx_fire) phase_next = sum_ok ? PH_TAIL : PH_HEADER;
      end
      PH_TAIL: begin
        if (rx_fire) begin
          if (b == tail_byte && held_length != '0) phase_next = PH_EMIT_RD;
          else phase_next = PH_HEADER;
        end
      end
      PH_EMIT_RD: phase_next = PH_EMIT_WR;
      PH_EMIT_WR: begin
        if (out_free) phase_next = emit_last ? PH_HEADER : PH_EMIT_RD;
      end
      default: phase_next = PH_HEADER;
    endcase
  end

  // handshake, memory strobes and result load
  always_comb begin
    rx_ready   = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    out_load   = 1'b0;
    ld_status  = ST_OK;
    ld_command = '0;
    ld_length  = '0;
    ld_payload = '0;
    ld_pos     = '0;
    ld_last    = 1'b1;
    unique case (phase)
      PH_HEADER: begin
        rx_ready = out_free;
        if (rx_fire && b != header_byte) begin
          out_load  = 1'b1;
          ld_status = ST_BAD_HEAD;
        end
      end
      PH_COMMAND: rx_ready = out_free;
      PH_LENGTH: begin
        rx_ready = out_free;
        if (rx_fire && !len_ok) begin
          out_load  = 1'b1;
          ld_status = ST_TOO_LONG;
        end
      end
      PH_PAYLOAD: begin
        rx_ready = out_free;
        mem_we   = rx_fire;
      end
      PH_CHECK: begin
        rx_ready = out_free;
        if (rx_fire && !sum_ok) begin
          out_load  = 1'b1;
          ld_status = ST_BAD_SUM;
        end
      end
      PH_TAIL: begin
        rx_ready = out_free;
        if (rx_fire && b != tail_byte) begin
          out_load  = 1'b1;
          ld_status = ST_BAD_TAIL;
        end else if (rx_fire && held_length == '0) begin
          // empty frame: one result carrying only the command
          out_load   = 1'b1;
          ld_command = held_command;
        end
      end
      PH_EMIT_RD: mem_re = 1'b1;
      PH_EMIT_WR: begin
        if (out_free) begin
          out_load   = 1'b1;
          ld_command = held_command;
          ld_length  = held_length;
          ld_payload = mem_rdata;
          ld_pos     = POS_W'(emit_idx);
          ld_last    = emit_last;
        end
      end
      default: rx_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte  <= '0;
      tail_byte    <= '0;
      max_length   <= LEN_W'(MAX_PAYLOAD);
      phase        <= PH_HEADER;
      held_command <= '0;
      held_length  <= '0;
      fill_index   <= '0;
      emit_idx     <= '0;
      running_xor  <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_HEADER: header_byte <= cfg_data;
          CFG_TAIL:   tail_byte   <= cfg_data;
          CFG_MAXLEN: max_length  <= cfg_data[LEN_W-1:0];
          default:    ;
        endcase
      end
      phase <= phase_next;
      if (rx_fire) begin
        case (phase)
          PH_COMMAND: begin
            held_command <= b;
            running_xor  <= b;
          end
          PH_LENGTH: begin
            running_xor <= running_xor ^ b;
            held_length <= b[LEN_W-1:0];
            fill_index  <= '0;
          end
          PH_PAYLOAD: begin
            running_xor <= running_xor ^ b;
            fill_index  <= fill_index + 1'b1;
          end
          PH_TAIL: emit_idx <= '0;
          default: ;
        endcase
      end
      if (phase == PH_EMIT_WR && out_free) begin
        emit_idx <= emit_idx + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status  <= ld_status;
      out_command <= ld_command;
      out_length  <= ld_length;
      out_payload <= ld_payload;
      out_pos     <= ld_pos;
      out_last    <= ld_last;
    end
  end

  assign rx.ready          = rx_ready;
  assign res.valid         = out_valid;
  assign res.status        = out_status;
  assign res.command_code  = out_command;
  assign res.frame_length  = out_length;
  assign res.payload_byte  = out_payload;
  assign res.byte_position = out_pos;
  assign res.last          = out_last;

`ifndef NO_ASSERTIONS
  a_no_rx_in_replay: assert property (@(posedge clk) disable iff (rst)
    rx.ready |-> !(phase == PH_EMIT_RD || phase == PH_EMIT_WR))
    else $error("rx ready during payload replay");

  a_fill_in_range: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> fill_index < CNT_W'(held_length))
    else $error("fill index past frame length");

  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_EMIT_RD || phase == PH_EMIT_WR) |-> emit_idx < CNT_W'(held_length))
    else $error("replay index past frame length");

  a_last_ends_replay: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_EMIT_WR && out_load && ld_last) |=> phase == PH_HEADER)
    else $error("replay continued after last beat");

  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != ST_OK) |-> (out_last && out_command == '0))
    else $error("error result not a single zeroed beat");
`endif

endmodule

[src/fpp_ram.sv]
module fpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[dv/tb_top.sv]
module tb_top;
  import fpp_pkg::*;

  localparam int SETTLE_CYCLES = 2 * MAX_PAYLOAD + 16;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct packed {
    status_t           status;
    logic [BYTE_W-1:0] command_code;
    logic [LEN_W-1:0]  frame_length;
    logic [BYTE_W-1:0] payload_byte;
    logic [POS_W-1:0]  byte_position;
    logic              last;
  } frame_result_t;

  typedef enum {FR_GOOD, FR_BAD_SUM, FR_BAD_TAIL, FR_TOO_LONG} frame_flaw_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_data;

  fpp_in_if  rx_link ();
  fpp_out_if res_link ();

  framed_packet_parser_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx        (rx_link),
    .res       (res_link)
  );

  always #10 clk = ~clk;

  // parser copy: registers and frame state
  logic [7:0]       hdr_cfg    = 8'd0;
  logic [7:0]       tail_cfg   = 8'd0;
  logic [5:0]       maxlen_cfg = 6'd32;
  phase_t           rx_phase   = PH_HEADER;
  logic [7:0]       held_cmd   = 8'd0;
  logic [LEN_W-1:0] held_len   = '0;
  int               fill_idx   = 0;
  logic [7:0]       run_xor    = 8'd0;
  logic [7:0]       pay_copy [MAX_PAYLOAD];

  frame_result_t awaited_results[$];
  logic [7:0]    pending_bytes[$];
  int            bytes_queued = 0;
  int            bytes_taken  = 0;
  int            mismatches   = 0;
  int unsigned   cycles       = 0;

  logic calm     = 1'b0;
  logic rx_beat  = 1'b0;
  int   rx_gap   = 0;
  int   stall_left = 0;

  function automatic int eff_limit();
    return (int'(maxlen_cfg) < MAX_PAYLOAD) ? int'(maxlen_cfg) : MAX_PAYLOAD;
  endfunction

  function automatic void push_flag(status_t st);
    awaited_results.push_back('{st, 8'd0, 6'd0, 8'd0, 5'd0, 1'b1});
  endfunction

  function automatic void parse_rx(logic [7:0] b);
    case (rx_phase)
      PH_COMMAND: begin
        held_cmd = b;
        run_xor  = b;
        rx_phase = PH_LENGTH;
      end
      PH_LENGTH: begin
        run_xor ^= b;
        if (int'(b) > eff_limit()) begin
          rx_phase = PH_HEADER;
          push_flag(ST_TOO_LONG);
        end else begin
          held_len = b[LEN_W-1:0];
          fill_idx = 0;
          if (b == 8'd0) rx_phase = PH_CHECK;
          else rx_phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (fill_idx < MAX_PAYLOAD) pay_copy[fill_idx] = b;
        fill_idx++;
        run_xor ^= b;
        if (fill_idx >= int'(held_len)) rx_phase = PH_CHECK;
      end
      PH_CHECK: begin
        if (run_xor == b) begin
          rx_phase = PH_TAIL;
        end else begin
          rx_phase = PH_HEADER;
          push_flag(ST_BAD_SUM);
        end
      end
      PH_TAIL: begin
        rx_phase = PH_HEADER;
        if (b != tail_cfg) begin
          push_flag(ST_BAD_TAIL);
        end else if (held_len == '0) begin
          awaited_results.push_back('{ST_OK, held_cmd, 6'd0, 8'd0, 5'd0, 1'b1});
        end else begin
          for (int i = 0; i < int'(held_len) && i < MAX_PAYLOAD; i++)
            awaited_results.push_back('{ST_OK, held_cmd, held_len, pay_copy[i], 5'(i),
                                        (i + 1 == int'(held_len))});
        end
      end
      default: begin
        rx_phase = PH_HEADER;
        if (b == hdr_cfg) rx_phase = PH_COMMAND;
        else push_flag(ST_BAD_HEAD);
      end
    endcase
  endfunction

  function automatic void check_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // sampling at the rising edge: input beats feed the parser copy, result beats are checked
  always @(posedge clk) begin
    frame_result_t exp_res;
    cycles++;
    rx_beat <= !rst && rx_link.valid && rx_link.ready;
    if (!rst && rx_link.valid && rx_link.ready) begin
      bytes_taken++;
      parse_rx(rx_link.rx_byte);
    end
    if (!rst && res_link.valid && res_link.ready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: result beat with none expected, status %0d cmd %0d len %0d byte %0d",
                 $time, res_link.status, res_link.command_code, res_link.frame_length,
                 res_link.payload_byte);
        mismatches++;
      end else begin
        exp_res = awaited_results.pop_front();
        check_field("status", int'(exp_res.status), int'(res_link.status));
        check_field("command_code", int'(exp_res.command_code), int'(res_link.command_code));
        check_field("frame_length", int'(exp_res.frame_length), int'(res_link.frame_length));
        check_field("payload_byte", int'(exp_res.payload_byte), int'(res_link.payload_byte));
        check_field("byte_position", int'(exp_res.byte_position),
                    int'(res_link.byte_position));
        check_field("last", int'(exp_res.last), int'(res_link.last));
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // byte driver
  always @(negedge clk) begin
    if (rst) begin
      rx_link.valid   <= 1'b0;
      rx_link.rx_byte <= 8'd0;
    end else if (rx_link.valid && !rx_beat) begin
      // hold the beat until it is taken
    end else if (rx_gap != 0) begin
      rx_link.valid <= 1'b0;
      rx_gap <= rx_gap - 1;
    end else if (pending_bytes.size() != 0) begin
      rx_link.valid   <= 1'b1;
      rx_link.rx_byte <= pending_bytes.pop_front();
      rx_gap <= pick_idle();
    end else begin
      rx_link.valid <= 1'b0;
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (stall_left != 0) begin
      res_link.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      res_link.ready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) stall_left <= pick_idle();
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    bytes_queued++;
  endtask

  task automatic push_frame(input logic [7:0] cmd, input logic [7:0] len_byte,
                            input frame_flaw_t flaw);
    logic [7:0] x;
    logic [7:0] d;
    queue_byte(hdr_cfg);
    queue_byte(cmd);
    queue_byte(len_byte);
    if (flaw == FR_TOO_LONG) return;
    x = cmd ^ len_byte;
    for (int i = 0; i < int'(len_byte); i++) begin
      d = 8'($urandom_range(0, 255));
      queue_byte(d);
      x ^= d;
    end
    if (flaw == FR_BAD_SUM) begin
      queue_byte(x ^ (8'd1 << $urandom_range(0, 7)));
      return;
    end
    queue_byte(x);
    if (flaw == FR_BAD_TAIL) queue_byte(tail_cfg ^ 8'($urandom_range(1, 255)));
    else queue_byte(tail_cfg);
  endtask

  task automatic random_traffic(input int n);
    int stop;
    int lim;
    int r;
    int pick;
    logic [7:0] d;
    stop = bytes_queued + n;
    lim  = eff_limit();
    while (bytes_queued < stop) begin
      r = $urandom_range(0, 99);
      // mostly short payloads, now and then up to the limit
      if ($urandom_range(0, 9) == 0) pick = $urandom_range(0, lim);
      else pick = $urandom_range(0, (lim < 4) ? lim : 4);
      if (r < 65) begin
        push_frame(8'($urandom_range(0, 255)), 8'(pick), FR_GOOD);
      end else if (r < 73) begin
        push_frame(8'($urandom_range(0, 255)), 8'(pick), FR_BAD_SUM);
      end else if (r < 80) begin
        push_frame(8'($urandom_range(0, 255)), 8'(pick), FR_BAD_TAIL);
      end else if (r < 87) begin
        push_frame(8'($urandom_range(0, 255)), 8'($urandom_range(lim + 1, 255)), FR_TOO_LONG);
      end else begin
        d = 8'($urandom_range(0, 255));
        if (d == hdr_cfg) d = ~d;
        queue_byte(d);
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (bytes_taken != bytes_queued || awaited_results.size() != 0);
  endtask

  // drain the traffic, then idle for SETTLE_CYCLES before going on
  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_HEADER: hdr_cfg = val;
      CFG_TAIL:   tail_cfg = val;
      CFG_MAXLEN: maxlen_cfg = val[5:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input logic [7:0] hdr, input logic [7:0] tail,
                              input logic [7:0] maxlen, input logic quiet, input int n);
    settle();
    write_reg(CFG_HEADER, hdr);
    write_reg(CFG_TAIL, tail);
    write_reg(CFG_MAXLEN, maxlen);
    calm = quiet;
    random_traffic(n / 2);
    // sender holds off until every result is back
    wait_drained();
    random_traffic(n - n / 2);
  endtask

  initial begin
    cfg_we          = 1'b0;
    cfg_index       = CFG_HEADER;
    cfg_data        = 8'd0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // reset settings: header and tail both zero, full limit
    queue_byte(8'h55);
    push_frame(8'hFF, 8'd0, FR_GOOD);
    push_frame(8'h00, 8'd1, FR_GOOD);

    settle();
    write_reg(CFG_HEADER, 8'hFF);
    write_reg(CFG_TAIL, 8'hFF);
    write_reg(CFG_MAXLEN, 8'd32);
    push_frame(8'hA5, 8'd32, FR_GOOD);
    push_frame(8'h5A, 8'd33, FR_TOO_LONG);
    push_frame(8'h3C, 8'hFF, FR_TOO_LONG);
    push_frame(8'hC3, 8'd2, FR_BAD_SUM);
    push_frame(8'h0F, 8'd1, FR_BAD_TAIL);

    settle();
    write_reg(CFG_MAXLEN, 8'd0);
    push_frame(8'h11, 8'd1, FR_TOO_LONG);
    push_frame(8'h22, 8'd0, FR_GOOD);

    // limit register above the buffer size is clamped
    settle();
    write_reg(CFG_MAXLEN, 8'd63);
    push_frame(8'h33, 8'd33, FR_TOO_LONG);
    push_frame(8'h44, 8'd3, FR_GOOD);

    random_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd32, 1'b0, 4);
    random_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(1, 63)), 1'b1, 4);
    random_phase(8'h00, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 8)), 1'b0, 4);
    random_phase(8'($urandom_range(0, 255)), 8'h00, 8'd32, 1'b0, 4);

    settle();
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
